// File: rtl/gsg_pkg.sv
// ----------------------------------------------------------------------------
// gsg_pkg: shared types and constants for the genetic search generation step
// Field widths, fitness constants, the controller state type and the command
// bundle that the controller hands to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gsg_pkg;

    // Fixed field widths of the item and result channels.
    localparam int FUNC_W  = 1;
    localparam int RANK_W  = 2;
    localparam int GENES_W = 6;
    localparam int POS_W   = 3;
    localparam int SCORE_W = 21;

    // Default sizing handed down from the top level.
    localparam int POP_SIZE_DEF   = 4;
    localparam int GENE_COUNT_DEF = 6;

    // Fitness is FIT_BIAS - x^4, clamped from below at SCORE_MIN.
    localparam int FIT_BIAS   = 9;
    localparam int SCORE_MIN  = -1048576;
    localparam int BEST_RESET = -923512;

    // Item function codes.
    localparam logic [FUNC_W-1:0] FUNC_LOAD = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_GEN  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SCORE,
        ST_DRAIN,
        ST_SORT,
        ST_PUBLISH
    } gsg_state_t;

    typedef struct packed {
        logic capture;      // register the accepted item fields
        logic apply;        // write the load or the crossover and mutation
        logic score_issue;  // start scoring the entry at the count
        logic sort_pass;    // one odd-even compare and swap pass
        logic publish;      // update the best score and load the result
    } gsg_cmd_t;

endpackage

`default_nettype wire

// File: rtl/gsg_item_if.sv
// ----------------------------------------------------------------------------
// gsg_item_if: item channel of the genetic search generation step
// Valid and ready handshake carrying one load or generation item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gsg_item_if
    import gsg_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [RANK_W-1:0]   load_rank;
    logic [GENES_W-1:0]  load_genes;
    logic [POS_W-1:0]    cross_point;
    logic [RANK_W-1:0]   mutate_rank;
    logic [POS_W-1:0]    mutate_gene;

    modport source (
        output valid, func, load_rank, load_genes, cross_point, mutate_rank,
               mutate_gene,
        input  ready
    );

    modport sink (
        input  valid, func, load_rank, load_genes, cross_point, mutate_rank,
               mutate_gene,
        output ready
    );

endinterface

`default_nettype wire

// File: rtl/gsg_result_if.sv
// ----------------------------------------------------------------------------
// gsg_result_if: result channel of the genetic search generation step
// Valid and ready handshake carrying the best and top scores after an item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gsg_result_if
    import gsg_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SCORE_W-1:0]  best_score;
    logic [GENES_W-1:0]         top_genes;
    logic signed [SCORE_W-1:0]  top_score;

    modport source (
        output valid, best_score, top_genes, top_score,
        input  ready
    );

    modport sink (
        input  valid, best_score, top_genes, top_score,
        output ready
    );

endinterface

`default_nettype wire

// File: rtl/gsg_ctrl.sv
// ----------------------------------------------------------------------------
// gsg_ctrl: sequencer of the genetic search generation step
// Steps one item through apply, scoring, drain, sorting and publish, and owns
// the item and result handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsg_ctrl
    import gsg_pkg::*;
#(
    parameter int POP_SIZE = POP_SIZE_DEF,
    localparam int IDX_W   = (POP_SIZE > 1) ? $clog2(POP_SIZE) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output      logic             in_ready,
    input  wire logic             out_ready,
    output      logic             out_valid,
    output      gsg_cmd_t         cmd,
    output      logic [IDX_W-1:0] cnt
);

    localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(POP_SIZE - 1);

    gsg_state_t       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                cnt_next   = '0;
                state_next = ST_SCORE;
            end
            ST_SCORE:
            begin
                cmd.score_issue = 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // The last score is written at the end of this cycle.
                state_next = ST_SORT;
            end
            ST_SORT:
            begin
                cmd.sort_pass = 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_PUBLISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PUBLISH:
            begin
                if (slot_free)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign cnt       = cnt_reg;

endmodule

`default_nettype wire

// File: rtl/gsg_dp.sv
// ----------------------------------------------------------------------------
// gsg_dp: datapath of the genetic search generation step
// Holds the ranked population, applies loads, crossover and mutation, scores
// entries through one shared two-stage fourth-power unit and sorts by
// odd-even transposition passes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsg_dp
    import gsg_pkg::*;
#(
    parameter int POP_SIZE   = POP_SIZE_DEF,
    parameter int GENE_COUNT = GENE_COUNT_DEF,
    localparam int IDX_W     = (POP_SIZE > 1) ? $clog2(POP_SIZE) : 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire gsg_cmd_t                   cmd,
    input  wire logic [IDX_W-1:0]           cnt,
    input  wire logic [FUNC_W-1:0]          func,
    input  wire logic [RANK_W-1:0]          load_rank,
    input  wire logic [GENES_W-1:0]         load_genes,
    input  wire logic [POS_W-1:0]           cross_point,
    input  wire logic [RANK_W-1:0]          mutate_rank,
    input  wire logic [POS_W-1:0]           mutate_gene,
    output      logic signed [SCORE_W-1:0]  best_score,
    output      logic [GENES_W-1:0]         top_genes,
    output      logic signed [SCORE_W-1:0]  top_score
);

    localparam int MAG_W = GENE_COUNT - 1;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int P_W   = 4 * MAG_W;
    localparam int FIT_W = (P_W + 2 > SCORE_W + 1) ? P_W + 2 : SCORE_W + 1;

    localparam logic signed [FIT_W-1:0]   SAT_LO   = FIT_W'(SCORE_MIN);
    localparam logic signed [FIT_W-1:0]   BIAS     = FIT_W'(FIT_BIAS);
    localparam logic signed [SCORE_W-1:0] SCORE_LO = SCORE_W'(SCORE_MIN);
    localparam logic signed [SCORE_W-1:0] SCORE_RST = SCORE_W'(FIT_BIAS);
    localparam logic signed [SCORE_W-1:0] BEST_RST = SCORE_W'(BEST_RESET);
    localparam logic [POS_W-1:0]          POS_ONE  = POS_W'(1);

    // Captured item.
    logic [FUNC_W-1:0]  func_reg;
    logic [RANK_W-1:0]  load_rank_reg;
    logic [GENES_W-1:0] load_genes_reg;
    logic [POS_W-1:0]   cross_point_reg;
    logic [RANK_W-1:0]  mutate_rank_reg;
    logic [POS_W-1:0]   mutate_gene_reg;

    // Population, kept in rank order once sorted.
    logic [GENE_COUNT-1:0]     genes_reg  [POP_SIZE];
    logic [GENE_COUNT-1:0]     genes_next [POP_SIZE];
    logic signed [SCORE_W-1:0] score_reg  [POP_SIZE];
    logic signed [SCORE_W-1:0] score_next [POP_SIZE];

    logic signed [SCORE_W-1:0] best_reg, best_next;
    logic [GENES_W-1:0]        top_genes_reg;
    logic signed [SCORE_W-1:0] top_score_reg;

    // Fitness unit: square in the first stage, square and bias in the second.
    logic [SQ_W-1:0]  sq_reg;
    logic [IDX_W-1:0] fit_idx_reg;
    logic             fit_vld_reg;
    logic [MAG_W-1:0] mag;
    logic [SQ_W-1:0]  mag_ext;
    logic [P_W-1:0]   sq_ext;
    logic [P_W-1:0]   quad;
    logic signed [FIT_W-1:0]   diff;
    logic signed [SCORE_W-1:0] fit;

    // Crossover and mutation.
    logic [POS_W-1:0]      cp_eff;
    logic [POS_W-1:0]      mg_eff;
    logic [GENE_COUNT-1:0] xmask;
    logic [GENE_COUNT-1:0] fmask;
    logic                  load_ok;
    logic                  mut_ok;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg        <= func;
            load_rank_reg   <= load_rank;
            load_genes_reg  <= load_genes;
            cross_point_reg <= cross_point;
            mutate_rank_reg <= mutate_rank;
            mutate_gene_reg <= mutate_gene;
        end
        if (cmd.score_issue)
        begin
            sq_reg      <= mag_ext * mag_ext;
            fit_idx_reg <= cnt;
        end
        if (cmd.publish)
        begin
            top_genes_reg <= GENES_W'(genes_reg[0]);
            top_score_reg <= score_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_vld_reg <= 1'b0;
            best_reg    <= BEST_RST;
            for (int i = 0; i < POP_SIZE; i++)
            begin
                genes_reg[i] <= '0;
                score_reg[i] <= SCORE_RST;
            end
        end
        else
        begin
            fit_vld_reg <= cmd.score_issue;
            best_reg    <= best_next;
            for (int i = 0; i < POP_SIZE; i++)
            begin
                genes_reg[i] <= genes_next[i];
                score_reg[i] <= score_next[i];
            end
        end
    end

    assign mag     = genes_reg[cnt][MAG_W-1:0];
    assign mag_ext = SQ_W'(mag);
    assign sq_ext  = P_W'(sq_reg);
    assign quad    = sq_ext * sq_ext;
    assign diff    = BIAS - $signed(FIT_W'(quad));
    assign fit     = (diff < SAT_LO) ? SCORE_LO : diff[SCORE_W-1:0];

    assign cp_eff  = (cross_point_reg == '0) ? POS_ONE : cross_point_reg;
    assign mg_eff  = (mutate_gene_reg == '0) ? POS_ONE : mutate_gene_reg;
    assign load_ok = int'(load_rank_reg) < POP_SIZE;
    assign mut_ok  = int'(mutate_rank_reg) < POP_SIZE;

    // Gene position p is bit GENE_COUNT-1-p; crossover takes positions from
    // the crossover point to the end, so the low bits.
    always_comb
    begin
        for (int b = 0; b < GENE_COUNT; b++)
        begin
            xmask[b] = int'(cp_eff) <= GENE_COUNT - 1 - b;
            fmask[b] = int'(mg_eff) == GENE_COUNT - 1 - b;
        end
    end

    always_comb
    begin
        for (int i = 0; i < POP_SIZE; i++)
        begin
            genes_next[i] = genes_reg[i];
            score_next[i] = score_reg[i];
        end

        if (cmd.apply)
        begin
            if (func_reg == FUNC_LOAD)
            begin
                for (int i = 0; i < POP_SIZE; i++)
                begin
                    if (load_ok && int'(load_rank_reg) == i)
                    begin
                        genes_next[i] = GENE_COUNT'(load_genes_reg);
                    end
                end
            end
            else
            begin
                genes_next[0] = (genes_reg[0] & ~xmask) | (genes_reg[1] & xmask);
                genes_next[1] = (genes_reg[1] & ~xmask) | (genes_reg[0] & xmask);
                for (int i = 0; i < POP_SIZE; i++)
                begin
                    if (mut_ok && int'(mutate_rank_reg) == i)
                    begin
                        genes_next[i] = genes_next[i] ^ fmask;
                    end
                end
            end
        end

        if (fit_vld_reg)
        begin
            for (int i = 0; i < POP_SIZE; i++)
            begin
                if (int'(fit_idx_reg) == i)
                begin
                    score_next[i] = fit;
                end
            end
        end

        // Pairs of one parity are disjoint; a swap only on a strictly larger
        // lower neighbour keeps equal scores in their order.
        if (cmd.sort_pass)
        begin
            for (int i = 0; i < POP_SIZE - 1; i++)
            begin
                if ((i % 2) == int'(cnt[0]) && score_reg[i] < score_reg[i + 1])
                begin
                    genes_next[i]     = genes_reg[i + 1];
                    genes_next[i + 1] = genes_reg[i];
                    score_next[i]     = score_reg[i + 1];
                    score_next[i + 1] = score_reg[i];
                end
            end
        end
    end

    always_comb
    begin
        best_next = best_reg;
        if (cmd.publish && score_reg[0] > best_reg)
        begin
            best_next = score_reg[0];
        end
    end

    assign best_score = best_reg;
    assign top_genes  = top_genes_reg;
    assign top_score  = top_score_reg;

endmodule

`default_nettype wire

// File: rtl/genetic_search_generation_step.sv
// ----------------------------------------------------------------------------
// genetic_search_generation_step: ranked population with crossover and mutation
// Usage
//   The item channel takes one beat per item: func selects a load of one
//   chromosome at load_rank or one generation step (crossover between ranks 0
//   and 1 at cross_point and a gene flip at mutate_rank and mutate_gene).
//   After every item each entry is rescored and the population re-sorted.
//   The result channel gives one beat per item: the best top score since
//   reset, and the chromosome and score now ranked first.
//   Sequence: an item is taken in the idle state; the controller then applies
//   it, scores one entry a cycle through the shared fourth-power unit, passes
//   a drain state, runs POP_SIZE odd-even sort passes and publishes the result.
//   One item is in flight at a time; ready is high only while idle.
//   Stall: the result sits in an output register. The next item is accepted
//   while it waits; that item's result is held back until the earlier beat
//   has been taken.
//   Reset: every entry holds zero genes with score 9, best score -923512.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module genetic_search_generation_step
    import gsg_pkg::*;
#(
    parameter int POP_SIZE   = POP_SIZE_DEF,
    parameter int GENE_COUNT = GENE_COUNT_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    gsg_item_if.sink   item,
    gsg_result_if.source result
);

    localparam int IDX_W = (POP_SIZE > 1) ? $clog2(POP_SIZE) : 1;

    gsg_cmd_t         cmd;
    logic [IDX_W-1:0] cnt;

    gsg_ctrl #(
        .POP_SIZE (POP_SIZE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .cmd       (cmd),
        .cnt       (cnt)
    );

    gsg_dp #(
        .POP_SIZE   (POP_SIZE),
        .GENE_COUNT (GENE_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cnt         (cnt),
        .func        (item.func),
        .load_rank   (item.load_rank),
        .load_genes  (item.load_genes),
        .cross_point (item.cross_point),
        .mutate_rank (item.mutate_rank),
        .mutate_gene (item.mutate_gene),
        .best_score  (result.best_score),
        .top_genes   (result.top_genes),
        .top_score   (result.top_score)
    );

endmodule

`default_nettype wire
